// File: sv/brf_pkg.sv
// brf_pkg: shared types and constants for the blended rectangle fill framebuffer
// no dependencies; imported by brf_blend and blended_rect_fill_framebuffer_unit

package brf_pkg;

  // default canvas store size
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // field widths
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int FIELD_W   = 13;
  localparam int BYTE_W    = 8;
  localparam int PIXEL_W   = 4 * BYTE_W;
  // signed width that holds any band edge or edge sum
  localparam int SPAN_W    = 18;

  localparam logic [BYTE_W-1:0] OPAQUE = 8'hFF;
  localparam int NUM_BANDS = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_ORDER    = 2'd2;

  typedef enum logic [2:0] {
    CMD_PLOT  = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_FRAME = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BAND,
    S_ORIGIN,
    S_PRD,
    S_PMIX,
    S_PWR,
    S_DONE
  } state_t;

  // source color and channel order seen by the blend unit
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
    logic              swap;
  } blend_src_t;

endpackage

// File: sv/brf_blend.sv
// brf_blend: per-pixel blend unit, three channel lanes plus opaque fourth byte
// depends on brf_pkg

module brf_blend (
  input  brf_pkg::blend_src_t src,
  input  logic [31:0]         old_word,
  output logic [31:0]         new_word
);
  import brf_pkg::*;

  // (s*a + d*(255-a)) / 255, divide done as (v + 1 + (v >> 8)) >> 8
  function automatic logic [BYTE_W-1:0] mix(input logic [BYTE_W-1:0] s,
                                             input logic [BYTE_W-1:0] d,
                                             input logic [BYTE_W-1:0] a);
    logic [15:0] v;
    logic [16:0] q;
    v = s * a + d * (OPAQUE - a);
    q = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return q[15:8];
  endfunction

  logic [BYTE_W-1:0] s0, s2;
  logic [BYTE_W-1:0] n0, n1, n2;

  always_comb begin
    s0 = src.swap ? src.blue : src.red;
    s2 = src.swap ? src.red  : src.blue;
    if (src.alpha == OPAQUE) begin
      n0 = s0;
      n1 = src.green;
      n2 = s2;
    end else begin
      n0 = mix(s0,        old_word[7:0],   src.alpha);
      n1 = mix(src.green, old_word[15:8],  src.alpha);
      n2 = mix(s2,        old_word[23:16], src.alpha);
    end
    new_word = {OPAQUE, n2, n1, n0};
  end

endmodule

// File: sv/blended_rect_fill_framebuffer_unit.sv
// plot, fill, clear, frame: per band a clip step (S_BAND), an empty band being skipped, then the
// origin step (S_ORIGIN) and for each clipped pixel a read, a blend and a write (S_PRD, S_PMIX,
// S_PWR) on the one-read one-write pixel memory; an in-range read stops after S_PMIX
// one item at a time: in_stall stays high until the result is moved to the output register
// reset and every canvas_width or canvas_height write run a clearing pass that zeroes all
// MAX_WIDTH*MAX_HEIGHT words (65536 by default), no input beat is taken meanwhile

module blended_rect_fill_framebuffer_unit #(
  parameter int MAX_WIDTH  = brf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = brf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [12:0] pos_x,
  input  logic [12:0] pos_y,
  input  logic [12:0] rect_w,
  input  logic [12:0] rect_h,
  input  logic [12:0] thickness,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  alpha,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  first_byte,
  output logic [7:0]  second_byte,
  output logic [7:0]  third_byte,
  output logic [7:0]  fourth_byte,
  output logic        in_range
);
  import brf_pkg::*;

  // coordinate widths hold 0..MAX inclusive, address spans the whole store
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CH    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [CFG_W-1:0] canvas_width;
  logic [CFG_W-1:0] canvas_height;
  logic             swap_order;

  // effective canvas size, clamped to the store
  logic [CW-1:0] eff_w;
  logic [CH-1:0] eff_h;

  // sequencer
  state_t state, state_next;
  logic   size_write;
  logic   accept;
  cmd_t   cmd_in;
  logic   rd_in;

  // latched command
  cmd_t                      cmd_q;
  logic signed [FIELD_W-1:0] px, py, pw, ph, pt;
  blend_src_t                src_q;
  logic [1:0]                band;
  logic                      last_band;

  // band geometry and clipping
  logic signed [SPAN_W-1:0] xs, ys, ws, hs, ts, effw_s, effh_s;
  logic signed [SPAN_W-1:0] bx, by, bw, bh;
  logic signed [SPAN_W-1:0] x0c, y0c, x1c, y1c;
  logic                     band_empty;

  // pixel walk
  logic [CW-1:0]    x0, x1, cx;
  logic [CH-1:0]    y0, y1, cy;
  logic [AW-1:0]    addr, row_addr, origin;
  logic [CH+CW-1:0] row_prod;
  logic             x_more, y_more;
  logic [AW-1:0]    clr_addr;

  // pixel memory
  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;

  // blend unit
  logic [PIXEL_W-1:0] blend_word;
  logic [PIXEL_W-1:0] new_word;

  // pending result
  logic [BYTE_W-1:0] res_b0, res_b1, res_b2, res_b3;
  logic              res_in;
  logic              out_free;
  logic              out_load;

  // ---------------------------------------------------------------------------
  // configuration

  assign size_write = cfg_write &&
                      (cfg_index == REG_CANVAS_WIDTH || cfg_index == REG_CANVAS_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CFG_W'(256);
      canvas_height <= CFG_W'(256);
      swap_order    <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        REG_SWAP_ORDER:    swap_order    <= cfg_data[0];
        default: ;  // unknown index is ignored
      endcase
    end
  end

  assign eff_w = (32'(canvas_width)  < MAX_WIDTH)  ? CW'(canvas_width)  : CW'(MAX_WIDTH);
  assign eff_h = (32'(canvas_height) < MAX_HEIGHT) ? CH'(canvas_height) : CH'(MAX_HEIGHT);

  // ---------------------------------------------------------------------------
  // input decode

  assign accept = in_valid && !in_stall;
  assign cmd_in = cmd_t'(command);

  // read position check straight off the input beat
  assign rd_in = !pos_x[FIELD_W-1] && !pos_y[FIELD_W-1] &&
                 ({2'b00, pos_x[FIELD_W-2:0]} < (FIELD_W+1)'(eff_w)) &&
                 ({2'b00, pos_y[FIELD_W-2:0]} < (FIELD_W+1)'(eff_h));

  assign last_band = (cmd_q != CMD_FRAME) || (band == 2'(NUM_BANDS - 1));

  // ---------------------------------------------------------------------------
  // band selection and clip against the canvas

  always_comb begin
    xs     = SPAN_W'(px);
    ys     = SPAN_W'(py);
    ws     = SPAN_W'(pw);
    hs     = SPAN_W'(ph);
    ts     = SPAN_W'(pt);
    effw_s = SPAN_W'($signed({1'b0, eff_w}));
    effh_s = SPAN_W'($signed({1'b0, eff_h}));
    case (cmd_q)
      CMD_PLOT: begin
        bx = xs;
        by = ys;
        bw = SPAN_W'(1);
        bh = SPAN_W'(1);
      end
      CMD_CLEAR: begin
        bx = '0;
        by = '0;
        bw = effw_s;
        bh = effh_s;
      end
      CMD_FRAME: begin
        // top, bottom, left, right bands
        case (band)
          2'd0: begin
            bx = xs;
            by = ys;
            bw = ws;
            bh = ts;
          end
          2'd1: begin
            bx = xs;
            by = ys + hs - ts;
            bw = ws;
            bh = ts;
          end
          2'd2: begin
            bx = xs;
            by = ys + ts;
            bw = ts;
            bh = hs - (ts <<< 1);
          end
          default: begin
            bx = xs + ws - ts;
            by = ys + ts;
            bw = ts;
            bh = hs - (ts <<< 1);
          end
        endcase
      end
      default: begin
        bx = xs;
        by = ys;
        bw = ws;
        bh = hs;
      end
    endcase

    x0c = bx[SPAN_W-1] ? '0 : bx;
    y0c = by[SPAN_W-1] ? '0 : by;
    x1c = bx + bw;
    y1c = by + bh;
    if (x1c > effw_s) begin
      x1c = effw_s;
    end
    if (y1c > effh_s) begin
      y1c = effh_s;
    end
    band_empty = (x0c >= x1c) || (y0c >= y1c);
  end

  // ---------------------------------------------------------------------------
  // walk stepping and rectangle origin address

  assign x_more   = ((CW+1)'(cx) + (CW+1)'(1)) < {1'b0, x1};
  assign y_more   = ((CH+1)'(cy) + (CH+1)'(1)) < {1'b0, y1};
  assign row_prod = y0 * eff_w;
  assign origin   = AW'(row_prod) + AW'(x0);

  // ---------------------------------------------------------------------------
  // next state

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_READ:  state_next = rd_in ? S_ORIGIN : S_DONE;
            CMD_PLOT,
            CMD_FILL,
            CMD_CLEAR,
            CMD_FRAME: state_next = S_BAND;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_BAND: begin
        if (!band_empty) begin
          state_next = S_ORIGIN;
        end else if (last_band) begin
          state_next = S_DONE;
        end
      end
      S_ORIGIN: state_next = S_PRD;
      S_PRD:    state_next = S_PMIX;
      S_PMIX:   state_next = (cmd_q == CMD_READ) ? S_DONE : S_PWR;
      S_PWR: begin
        if (x_more || y_more) begin
          state_next = S_PRD;
        end else if (last_band) begin
          state_next = S_DONE;
        end else begin
          state_next = S_BAND;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // a size change wipes the store whatever the sequencer was doing
    if (size_write) begin
      state_next = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    in_stall  = (state != S_IDLE);
    out_load  = (state == S_DONE) && out_free;
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = new_word;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_PWR: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // clearing pass counter

  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // command latch, band counter and pixel walk

  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
    end else if (accept) begin
      band <= '0;
    end else if (!last_band &&
                 ((state == S_BAND && band_empty) ||
                  (state == S_PWR && !x_more && !y_more))) begin
      band <= band + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= cmd_in;
      px          <= pos_x;
      py          <= pos_y;
      pw          <= rect_w;
      ph          <= rect_h;
      pt          <= thickness;
      src_q.red   <= red;
      src_q.green <= green;
      src_q.blue  <= blue;
      src_q.alpha <= (cmd_in == CMD_CLEAR) ? OPAQUE : alpha;
      src_q.swap  <= swap_order;
      // a read goes straight to the origin step with its own position
      x0          <= CW'({1'b0, pos_x[FIELD_W-2:0]});
      y0          <= CH'({1'b0, pos_y[FIELD_W-2:0]});
    end else if (state == S_BAND) begin
      x0 <= CW'(x0c);
      x1 <= CW'(x1c);
      y0 <= CH'(y0c);
      y1 <= CH'(y1c);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_ORIGIN: begin
        cx       <= x0;
        cy       <= y0;
        addr     <= origin;
        row_addr <= origin;
      end
      S_PWR: begin
        if (x_more) begin
          cx   <= cx + CW'(1);
          addr <= addr + AW'(1);
        end else if (y_more) begin
          // next row starts one canvas width further on
          cx       <= x0;
          cy       <= cy + CH'(1);
          row_addr <= row_addr + AW'(eff_w);
          addr     <= row_addr + AW'(eff_w);
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pixel memory: one write port, one registered read port

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[addr];
  end

  // ---------------------------------------------------------------------------
  // blend unit, result registered before the write-back

  brf_blend u_blend (
    .src      (src_q),
    .old_word (rdata),
    .new_word (blend_word)
  );

  always_ff @(posedge clk) begin
    if (state == S_PMIX) begin
      new_word <= blend_word;
    end
  end

  // ---------------------------------------------------------------------------
  // pending result: zero for drawing commands, pixel bytes for an in-range read

  always_ff @(posedge clk) begin
    if (accept) begin
      res_b0 <= '0;
      res_b1 <= '0;
      res_b2 <= '0;
      res_b3 <= '0;
      res_in <= (cmd_in == CMD_READ) && rd_in;
    end else if (state == S_PMIX && cmd_q == CMD_READ) begin
      res_b0 <= rdata[7:0];
      res_b1 <= rdata[15:8];
      res_b2 <= rdata[23:16];
      res_b3 <= rdata[31:24];
    end
  end

  // output register, frees as soon as the result beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      first_byte  <= res_b0;
      second_byte <= res_b1;
      third_byte  <= res_b2;
      fourth_byte <= res_b3;
      in_range    <= res_in;
    end
  end

  // ---------------------------------------------------------------------------
  // checks

  // a pixel being written lies inside the clipped band
  a_pix_in_band: assert property (@(posedge clk) disable iff (rst)
    (state == S_PWR) |-> ((cx < x1) && (cy < y1)))
    else $error("pixel write outside clipped band");

  // walk address follows row base plus column offset
  a_addr_track: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRD) |-> (addr == row_addr + AW'(cx) - AW'(x0)))
    else $error("pixel address out of step with walk");

  // an in-range read shows a cleared or a written pixel
  a_read_fourth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && in_range) |-> (fourth_byte == 8'd0 || fourth_byte == OPAQUE))
    else $error("read returned a fourth byte that was never written");

  // anything but an in-range read reports zero bytes
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !in_range) |->
      (first_byte == 8'd0 && second_byte == 8'd0 &&
       third_byte == 8'd0 && fourth_byte == 8'd0))
    else $error("non-read result carries pixel bytes");

endmodule
